// ===== hw/rtl/pps_pkg.sv =====
package pps_pkg;

   // largest number of reply bytes kept in the payload
   localparam int unsigned MaxReplyBytes = 8;

   localparam int unsigned HalfWidth  = 10;
   localparam int unsigned CountWidth = 11;

   // port bits
   localparam logic [7:0] PORT_POWER  = 8'hF8;
   localparam logic [7:0] PORT_CLOCK  = 8'h04;
   localparam logic [7:0] PORT_SELECT = 8'h02;
   localparam logic [7:0] PORT_CMD    = 8'h01;

   localparam logic [7:0] CMD_START   = 8'h01;
   localparam logic [7:0] CMD_POLL    = 8'h42;
   localparam logic [7:0] CMD_IDLE    = 8'h00;
   localparam logic [7:0] ACK_BYTE    = 8'h5A;
   localparam logic [7:0] STATUS_FLIP = 8'h80;

   // byte positions in the sequence
   localparam logic [3:0] BYTE_START = 4'd0;
   localparam logic [3:0] BYTE_ID    = 4'd1;
   localparam logic [3:0] BYTE_ACK   = 4'd2;
   localparam logic [3:0] BYTE_DATA  = 4'd3;

   // register indexes
   localparam logic [1:0] REG_HALF_BIT_TICKS = 2'd0;
   localparam logic [1:0] REG_PACKET_BYTES   = 2'd1;
   localparam logic [1:0] REG_LINE_MASK      = 2'd2;

   localparam logic [HalfWidth-1:0] HALF_BIT_TICKS_RESET = 10'd10;
   localparam logic [3:0]           PACKET_BYTES_RESET   = 4'd6;
   localparam logic [7:0]           LINE_MASK_RESET      = 8'd64;

   typedef struct packed {
      logic [HalfWidth-1:0] half_bit_ticks;
      logic [3:0]           packet_bytes;
      logic [7:0]           line_mask;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  port_out;
      logic        busy_res;
      logic        done_res;
      logic        present;
      logic [7:0]  device_id;
      logic [63:0] payload;
   } result_type;

   function automatic logic [7:0] command_for(input logic [3:0] idx);
      logic [7:0] cmd;
      if (idx == BYTE_START) begin
         cmd = CMD_START;
      end else if (idx == BYTE_ID) begin
         cmd = CMD_POLL;
      end else begin
         cmd = CMD_IDLE;
      end
      return cmd;
   endfunction

endpackage

// ===== hw/rtl/pps_seq.sv =====
module pps_seq
   import pps_pkg::*;
#(
   parameter int unsigned MaxReply = MaxReplyBytes
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       start,
   input  logic [7:0] status_in,
   input  cfg_type    cfg,
   output result_type result
);

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_SELECT = 3'd1,
      PH_LOW    = 3'd2,
      PH_HIGH   = 3'd3,
      PH_FINISH = 3'd4
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [CountWidth-1:0]  tick_ff, tick_in;
   logic [2:0]             bit_ff, bit_in;
   logic [3:0]             byte_ff, byte_in;
   logic [7:0]             send_ff, send_in;
   logic [7:0]             recv_ff, recv_in;
   logic [7:0]             id_ff, id_in;
   logic [63:0]            payload_ff, payload_in;
   logic                   ack_ff, ack_in;
   logic [7:0]             port_ff, port_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [HalfWidth-1:0]   half;
   logic [CountWidth:0]    tick_next;
   logic                   end_half;
   logic                   end_select;
   logic [3:0]             reply_n;
   logic                   cmd_bit;
   logic                   data_bit;
   logic                   ack_new;
   logic [3:0]             data_idx;
   logic [3:0]             data_cnt;
   logic [3:0]             byte_next;
   logic                   finish;

   always_comb begin
      half       = (cfg.half_bit_ticks == '0) ? HalfWidth'(1) : cfg.half_bit_ticks;
      tick_next  = {1'b0, tick_ff} + (CountWidth+1)'(1);
      end_half   = tick_next >= (CountWidth+1)'(half);
      end_select = tick_next >= {1'b0, half, 1'b0};
      reply_n    = (cfg.packet_bytes > 4'(MaxReply)) ? 4'(MaxReply)
                                                     : cfg.packet_bytes;
      cmd_bit    = send_ff[bit_ff];
      data_bit   = |((status_in ^ STATUS_FLIP) & cfg.line_mask);
      ack_new    = (byte_ff == BYTE_ACK) ? (recv_ff == ACK_BYTE) : ack_ff;
      data_idx   = byte_ff - BYTE_DATA;
      data_cnt   = byte_ff - BYTE_ACK;
      byte_next  = byte_ff + 4'd1;
      finish     = ((byte_ff == BYTE_ACK) && (!ack_new || (reply_n == '0))) ||
                   ((byte_ff >= BYTE_DATA) && (data_cnt >= reply_n));
   end

   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      bit_in     = bit_ff;
      byte_in    = byte_ff;
      send_in    = send_ff;
      recv_in    = recv_ff;
      id_in      = id_ff;
      payload_in = payload_ff;
      ack_in     = ack_ff;
      port_in    = port_ff;
      busy_in    = 1'b1;
      done_in    = 1'b0;

      case (phase_ff)
         PH_SELECT: begin
            port_in = PORT_POWER | PORT_CLOCK | PORT_SELECT;
            if (end_select) begin
               byte_in  = BYTE_START;
               send_in  = command_for(BYTE_START);
               recv_in  = '0;
               bit_in   = '0;
               tick_in  = '0;
               phase_in = PH_LOW;
            end else begin
               tick_in = tick_next[CountWidth-1:0];
            end
         end
         PH_LOW: begin
            port_in = PORT_POWER | {7'd0, cmd_bit};
            if (end_half) begin
               if (data_bit) begin
                  recv_in[bit_ff] = 1'b1;
               end
               tick_in  = '0;
               phase_in = PH_HIGH;
            end else begin
               tick_in = tick_next[CountWidth-1:0];
            end
         end
         PH_HIGH: begin
            port_in = PORT_POWER | PORT_CLOCK | {7'd0, cmd_bit};
            if (end_half) begin
               tick_in = '0;
               if (bit_ff != 3'd7) begin
                  bit_in   = bit_ff + 3'd1;
                  phase_in = PH_LOW;
               end else begin
                  // byte done: store reply, then next byte or wrap up
                  if (byte_ff == BYTE_ID) begin
                     id_in = recv_ff;
                  end
                  ack_in = ack_new;
                  if (byte_ff >= BYTE_DATA) begin
                     for (int k = 0; k < 8; k++) begin
                        if (data_idx[2:0] == 3'(k)) begin
                           payload_in[k*8 +: 8] = payload_ff[k*8 +: 8] | recv_ff;
                        end
                     end
                  end
                  if (finish) begin
                     phase_in = PH_FINISH;
                  end else begin
                     byte_in  = byte_next;
                     send_in  = command_for(byte_next);
                     recv_in  = '0;
                     bit_in   = '0;
                     phase_in = PH_LOW;
                  end
               end
            end else begin
               tick_in = tick_next[CountWidth-1:0];
            end
         end
         PH_FINISH: begin
            port_in  = PORT_POWER | PORT_CLOCK | PORT_SELECT;
            busy_in  = 1'b0;
            done_in  = 1'b1;
            tick_in  = '0;
            phase_in = PH_IDLE;
         end
         default: begin
            if (start) begin
               port_in    = PORT_POWER;
               payload_in = '0;
               ack_in     = 1'b0;
               recv_in    = '0;
               byte_in    = '0;
               bit_in     = '0;
               tick_in    = '0;
               phase_in   = PH_SELECT;
            end else begin
               busy_in  = 1'b0;
               phase_in = PH_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         tick_ff    <= '0;
         bit_ff     <= '0;
         byte_ff    <= '0;
         send_ff    <= '0;
         recv_ff    <= '0;
         id_ff      <= '0;
         payload_ff <= '0;
         ack_ff     <= 1'b0;
         port_ff    <= PORT_POWER | PORT_CLOCK | PORT_SELECT;
         busy_ff    <= 1'b0;
         done_ff    <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         bit_ff     <= bit_in;
         byte_ff    <= byte_in;
         send_ff    <= send_in;
         recv_ff    <= recv_in;
         id_ff      <= id_in;
         payload_ff <= payload_in;
         ack_ff     <= ack_in;
         port_ff    <= port_in;
         busy_ff    <= busy_in;
         done_ff    <= done_in;
      end
   end

   assign result.port_out  = port_ff;
   assign result.busy_res  = busy_ff;
   assign result.done_res  = done_ff;
   assign result.present   = ack_ff;
   assign result.device_id = id_ff;
   assign result.payload   = payload_ff;

endmodule

// ===== hw/rtl/psx_pad_poll_sequencer_core.sv =====
// channel    | direction | handshake                 | payload
// -----------+-----------+---------------------------+------------------------------------
// request    | in        | req_valid / req_ready     | req_command, req_status_in
// response   | out       | rsp_valid / rsp_ready     | rsp_port_out, rsp_busy_res, ...
// csr        | in        | csr_psel / csr_penable    | csr_paddr, csr_pwdata, csr_prdata
//
// every request (one tick) yields exactly one response, via input and result register
// one request per clock while rsp_ready holds: input register -> tick logic -> result register
// the tick logic is one short next-state step; the state registers double as the result
// reset (synchronous, active high) returns the sequencer to idle with the port at 0xfe
// a stalled response holds both stages; ready flows back from rsp_ready
module psx_pad_poll_sequencer_core
   import pps_pkg::*;
#(
   // most reply bytes read per sequence, packet_bytes above this is clamped
   parameter int unsigned MaxReply = MaxReplyBytes
)
(
   input  logic        clock,
   input  logic        reset,

   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [7:0]  req_status_in,

   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_port_out,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic        rsp_present,
   output logic [7:0]  rsp_device_id,
   output logic [63:0] rsp_payload,

   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // input stage
   logic        in_valid_ff;
   logic        in_command_ff;
   logic [7:0]  in_status_ff;

   // result stage valid
   logic        out_valid_ff;

   // configuration registers
   cfg_type     cfg_ff;

   logic        out_advance;
   logic        in_advance;
   logic        csr_write;
   logic [1:0]  csr_index;
   result_type  result;

   // result stage can load when empty or being drained
   assign out_advance = !out_valid_ff || rsp_ready;
   // a request held in the input stage moves on into the sequencer
   assign in_advance  = in_valid_ff && out_advance;
   assign req_ready   = !in_valid_ff || out_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // request payload, captured with no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_command_ff <= req_command;
         in_status_ff  <= req_status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   // one tick of the poll sequence per accepted request
   pps_seq #(
      .MaxReply (MaxReply)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .step      (in_advance),
      .start     (in_command_ff),
      .status_in (in_status_ff),
      .cfg       (cfg_ff),
      .result    (result)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_port_out  = result.port_out;
   assign rsp_busy_res  = result.busy_res;
   assign rsp_done_res  = result.done_res;
   assign rsp_present   = result.present;
   assign rsp_device_id = result.device_id;
   assign rsp_payload   = result.payload;

   // csr access: zero wait states, word addressed
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_bit_ticks <= HALF_BIT_TICKS_RESET;
         cfg_ff.packet_bytes   <= PACKET_BYTES_RESET;
         cfg_ff.line_mask      <= LINE_MASK_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_HALF_BIT_TICKS: cfg_ff.half_bit_ticks <= csr_pwdata[HalfWidth-1:0];
            REG_PACKET_BYTES:   cfg_ff.packet_bytes   <= csr_pwdata[3:0];
            REG_LINE_MASK:      cfg_ff.line_mask      <= csr_pwdata[7:0];
            default: begin
               // unmapped address, write dropped
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_HALF_BIT_TICKS: csr_prdata = {22'd0, cfg_ff.half_bit_ticks};
         REG_PACKET_BYTES:   csr_prdata = {28'd0, cfg_ff.packet_bytes};
         REG_LINE_MASK:      csr_prdata = {24'd0, cfg_ff.line_mask};
         default:            csr_prdata = '0;
      endcase
   end

endmodule

// ===== tb/sv/tb_psx_pad_poll_sequencer_core.sv =====
import pps_pkg::*;

typedef enum logic [2:0] {
   SEQ_IDLE,
   SEQ_SELECT,
   SEQ_LOW,
   SEQ_HIGH,
   SEQ_FINISH
} seq_phase_type;

class pad_poll_tracker;
   logic [HalfWidth-1:0]  half_ticks;
   logic [3:0]            reply_bytes;
   logic [7:0]            line_mask;

   seq_phase_type         phase;
   logic [CountWidth-1:0] tick_cnt;
   logic [2:0]            bit_idx;
   logic [3:0]            byte_idx;
   logic [7:0]            tx_byte;
   logic [7:0]            rx_byte;
   logic [7:0]            id_byte;
   logic [7:0]            port_q;
   logic [63:0]           payload_acc;
   logic                  ack;

   result_type            expected_ticks[$];
   int                    errors;
   int                    responses;
   int                    finished;
   int                    good_acks;

   function new();
      half_ticks  = HALF_BIT_TICKS_RESET;
      reply_bytes = PACKET_BYTES_RESET;
      line_mask   = LINE_MASK_RESET;
      phase       = SEQ_IDLE;
      tick_cnt    = '0;
      bit_idx     = '0;
      byte_idx    = '0;
      tx_byte     = '0;
      rx_byte     = '0;
      id_byte     = '0;
      payload_acc = '0;
      ack         = 1'b0;
      port_q      = PORT_POWER | PORT_CLOCK | PORT_SELECT;
      errors      = 0;
      responses   = 0;
      finished    = 0;
      good_acks   = 0;
   endfunction

   function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
         REG_HALF_BIT_TICKS: half_ticks  = value[HalfWidth-1:0];
         REG_PACKET_BYTES:   reply_bytes = value[3:0];
         REG_LINE_MASK:      line_mask   = value[7:0];
         default: ;
      endcase
   endfunction

   // zero acts as one
   function int half_period();
      return (half_ticks == '0) ? 1 : int'(half_ticks);
   endfunction

   // the data bit is taken on this tick
   function bit sample_due();
      return (phase == SEQ_LOW) && (int'(tick_cnt) + 1 >= half_period());
   endfunction

   function void open_byte(logic [3:0] idx);
      byte_idx = idx;
      if (idx == BYTE_START) begin
         tx_byte = CMD_START;
      end else if (idx == BYTE_ID) begin
         tx_byte = CMD_POLL;
      end else begin
         tx_byte = CMD_IDLE;
      end
      rx_byte  = '0;
      bit_idx  = '0;
      tick_cnt = '0;
      phase    = SEQ_LOW;
   endfunction

   function void close_byte();
      int n;
      n = (reply_bytes > MaxReplyBytes) ? MaxReplyBytes : int'(reply_bytes);
      if (byte_idx == BYTE_ID) id_byte = rx_byte;
      if (byte_idx == BYTE_ACK) begin
         ack = (rx_byte == ACK_BYTE);
         if (ack) good_acks++;
      end
      if (byte_idx >= BYTE_DATA) begin
         payload_acc = payload_acc | ({56'd0, rx_byte} << (8 * ((int'(byte_idx) - 3) & 7)));
      end
      if (byte_idx == BYTE_ACK && (!ack || n == 0)) begin
         phase = SEQ_FINISH;
      end else if (byte_idx >= BYTE_DATA && int'(byte_idx) - 2 >= n) begin
         phase = SEQ_FINISH;
      end else begin
         open_byte(byte_idx + 4'd1);
      end
   endfunction

   function result_type step_sequencer(bit start, logic [7:0] status);
      result_type res;
      logic [7:0] port;
      logic       busy;
      logic       done;
      logic       cbit;
      busy = 1'b1;
      done = 1'b0;
      case (phase)
         SEQ_SELECT: begin
            port = PORT_POWER | PORT_CLOCK | PORT_SELECT;
            if (int'(tick_cnt) + 1 >= 2 * half_period()) open_byte(BYTE_START);
            else tick_cnt = tick_cnt + 1'b1;
         end
         SEQ_LOW: begin
            cbit = tx_byte[bit_idx];
            port = PORT_POWER | (cbit ? PORT_CMD : 8'h00);
            if (int'(tick_cnt) + 1 >= half_period()) begin
               if (((status ^ STATUS_FLIP) & line_mask) != 8'h00) rx_byte[bit_idx] = 1'b1;
               tick_cnt = '0;
               phase    = SEQ_HIGH;
            end else begin
               tick_cnt = tick_cnt + 1'b1;
            end
         end
         SEQ_HIGH: begin
            cbit = tx_byte[bit_idx];
            port = PORT_POWER | PORT_CLOCK | (cbit ? PORT_CMD : 8'h00);
            if (int'(tick_cnt) + 1 >= half_period()) begin
               tick_cnt = '0;
               if (bit_idx < 3'd7) begin
                  bit_idx = bit_idx + 3'd1;
                  phase   = SEQ_LOW;
               end else begin
                  close_byte();
               end
            end else begin
               tick_cnt = tick_cnt + 1'b1;
            end
         end
         SEQ_FINISH: begin
            port     = PORT_POWER | PORT_CLOCK | PORT_SELECT;
            busy     = 1'b0;
            done     = 1'b1;
            tick_cnt = '0;
            phase    = SEQ_IDLE;
            finished++;
         end
         default: begin
            if (start) begin
               port        = PORT_POWER;
               payload_acc = '0;
               ack         = 1'b0;
               rx_byte     = '0;
               byte_idx    = '0;
               bit_idx     = '0;
               tick_cnt    = '0;
               phase       = SEQ_SELECT;
            end else begin
               port = port_q;
               busy = 1'b0;
            end
         end
      endcase
      port_q        = port;
      res.port_out  = port;
      res.busy_res  = busy;
      res.done_res  = done;
      res.present   = ack;
      res.device_id = id_byte;
      res.payload   = payload_acc;
      return res;
   endfunction

   function void note_request(bit start, logic [7:0] status);
      expected_ticks.push_back(step_sequencer(start, status));
   endfunction

   function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   function void check_response(result_type got);
      result_type want;
      if (expected_ticks.size() == 0) begin
         $display("%0t: response with no request pending, actual %h", $time, got);
         errors++;
         return;
      end
      want = expected_ticks.pop_front();
      responses++;
      compare_field("port_out", 64'(want.port_out), 64'(got.port_out));
      compare_field("busy_res", 64'(want.busy_res), 64'(got.busy_res));
      compare_field("done_res", 64'(want.done_res), 64'(got.done_res));
      compare_field("present", 64'(want.present), 64'(got.present));
      compare_field("device_id", 64'(want.device_id), 64'(got.device_id));
      compare_field("payload", want.payload, got.payload);
   endfunction
endclass

module tb_psx_pad_poll_sequencer_core;
   timeunit 1ns;
   timeprecision 1ps;

   // worst case is far below this even with every stall at its longest
   localparam longint CycleLimit = 40_000_000;
   localparam int     ClockHalf  = 5;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;

   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic        req_command   = 1'b0;
   logic [7:0]  req_status_in = 8'h00;

   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic [7:0]  rsp_port_out;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic        rsp_present;
   logic [7:0]  rsp_device_id;
   logic [63:0] rsp_payload;

   logic        csr_psel      = 1'b0;
   logic        csr_penable   = 1'b0;
   logic        csr_pwrite    = 1'b0;
   logic [3:0]  csr_paddr     = 4'h0;
   logic [31:0] csr_pwdata    = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pad_poll_tracker tracker;

   // reply bytes the pad should appear to send in the running sequence
   logic [7:0]  reply_plan [0:10];
   bit          plan_shaped;
   // no idling on either side while set
   bit          steady        = 1'b0;
   int          ready_hold    = 0;
   int          ready_gap;
   int          settings_used = 0;
   longint      cycle_count   = 0;
   result_type  seen;

   psx_pad_poll_sequencer_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_status_in (req_status_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_port_out  (rsp_port_out),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_present   (rsp_present),
      .rsp_device_id (rsp_device_id),
      .rsp_payload   (rsp_payload),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #(ClockHalf) clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout with %0d responses outstanding", tracker.expected_ticks.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // idle length: mostly none or short, now and then long
   function automatic int gap_len();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // receiver stalls, changed only at the falling edge
   always @(negedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_ready) begin
         ready_gap = gap_len();
         if (ready_gap != 0) begin
            rsp_ready  <= 1'b0;
            ready_hold <= ready_gap - 1;
         end else begin
            ready_hold <= $urandom_range(0, 15);
         end
      end else begin
         rsp_ready  <= 1'b1;
         ready_hold <= $urandom_range(0, 15);
      end
   end

   // every accepted response is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen.port_out  = rsp_port_out;
         seen.busy_res  = rsp_busy_res;
         seen.done_res  = rsp_done_res;
         seen.present   = rsp_present;
         seen.device_id = rsp_device_id;
         seen.payload   = rsp_payload;
         tracker.check_response(seen);
      end
   end

   // one request = one tick; valid stays up across back-to-back requests
   task automatic send_tick(bit cmd, logic [7:0] status);
      int gap;
      gap = gap_len();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_status_in <= status;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(cmd, status);
   endtask

   task automatic csr_cycle(bit wr, logic [1:0] idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic read_back(logic [1:0] idx, logic [31:0] want);
      logic [31:0] got;
      csr_cycle(1'b0, idx, 32'h0, got);
      if (got !== want) begin
         $display("%0t: register %0d read mismatch, expected %h, actual %h",
                  $time, idx, want, got);
         tracker.errors++;
      end
   endtask

   task automatic program_register(logic [1:0] idx, logic [31:0] value);
      logic [31:0] unused;
      csr_cycle(1'b1, idx, value, unused);
      tracker.set_register(idx, value);
      read_back(idx, value);
   endtask

   // only called with the sequencer idle and every response in
   task automatic apply_setting(logic [9:0] half, logic [3:0] count, logic [7:0] mask);
      repeat (4) @(posedge clock);
      program_register(REG_HALF_BIT_TICKS, {22'd0, half});
      program_register(REG_PACKET_BYTES, {28'd0, count});
      program_register(REG_LINE_MASK, {24'd0, mask});
      settings_used++;
   endtask

   // most sequences are steered to a chosen reply, mostly with a good acknowledge
   task automatic plan_sequence();
      plan_shaped = ($urandom_range(0, 4) != 0);
      for (int i = 0; i <= 10; i++) reply_plan[i] = 8'($urandom);
      if ($urandom_range(0, 6) != 0) begin
         reply_plan[BYTE_ACK] = ACK_BYTE;
      end else begin
         // near miss on the acknowledge
         reply_plan[BYTE_ACK] = ACK_BYTE ^ (8'h01 << $urandom_range(0, 7));
      end
   endtask

   // status byte whose masked, flipped lines give the wanted data bit
   function automatic logic [7:0] shape_status(bit want);
      logic [7:0] x;
      int         j;
      x = 8'($urandom);
      if (tracker.line_mask == 8'h00) return x;
      if (want) begin
         do j = $urandom_range(0, 7); while (!tracker.line_mask[j]);
         x[j] = 1'b1;
      end else begin
         x = x & ~tracker.line_mask;
      end
      return x ^ STATUS_FLIP;
   endfunction

   task automatic next_tick(bit may_start);
      bit         cmd;
      logic [7:0] status;
      status = 8'($urandom);
      if (tracker.phase == SEQ_IDLE) begin
         cmd = may_start && ($urandom_range(0, 4) == 0);
         if (cmd) plan_sequence();
      end else begin
         // stray start while busy is ignored by the block
         cmd = ($urandom_range(0, 15) == 0);
         if (plan_shaped && tracker.sample_due()) begin
            status = shape_status(reply_plan[tracker.byte_idx][tracker.bit_idx]);
         end
      end
      send_tick(cmd, status);
   endtask

   // random ticks, then run out the open sequence and collect every response
   task automatic run_ticks(int count, bit no_gaps);
      steady = no_gaps;
      repeat (count) next_tick(1'b1);
      while (tracker.phase != SEQ_IDLE) next_tick(1'b0);
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.expected_ticks.size() != 0) @(posedge clock);
      steady = 1'b0;
   endtask

   initial begin
      tracker = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values of the registers
      read_back(REG_HALF_BIT_TICKS, {22'd0, HALF_BIT_TICKS_RESET});
      read_back(REG_PACKET_BYTES, {28'd0, PACKET_BYTES_RESET});
      read_back(REG_LINE_MASK, {24'd0, LINE_MASK_RESET});

      // idle port with extreme status bytes
      send_tick(1'b0, 8'h00);
      send_tick(1'b0, 8'hFF);
      send_tick(1'b0, STATUS_FLIP);
      send_tick(1'b0, 8'h7F);
      run_ticks(0, 1'b0);

      // shortest half period, one reply byte; second start lands in the select phase
      apply_setting(10'd1, 4'd1, 8'hFF);
      plan_sequence();
      plan_shaped = 1'b1;
      send_tick(1'b1, 8'hFF);
      send_tick(1'b1, 8'h00);
      run_ticks(0, 1'b1);

      // zero half period, full payload
      apply_setting(10'd0, 4'd8, 8'h01);
      run_ticks(150, 1'b0);

      // reply count above the payload size
      apply_setting(10'd2, 4'd15, 8'h80);
      run_ticks(200, 1'b0);

      // no lines selected: every acknowledge is bad
      apply_setting(10'd1, 4'd0, 8'h00);
      run_ticks(60, 1'b1);

      // zero reply bytes after a good acknowledge
      apply_setting(10'd1, 4'd0, 8'hC3);
      run_ticks(70, 1'b0);

      apply_setting(10'd3, 4'd3, 8'($urandom_range(1, 255)));
      run_ticks(110, 1'b0);

      apply_setting(10'd1, 4'd7, 8'($urandom_range(1, 255)));
      run_ticks(110, 1'b1);

      // widest half period value, register path only
      apply_setting(10'd1023, 4'd0, 8'h40);

      // longer half period, one full sequence without idling
      apply_setting(10'd4, 4'd0, 8'h40);
      plan_sequence();
      plan_shaped = 1'b1;
      send_tick(1'b1, 8'($urandom));
      run_ticks(0, 1'b1);

      apply_setting(10'd1, 4'd4, 8'($urandom));
      run_ticks(140, 1'b0);

      // drain margin
      repeat (10) @(posedge clock);

      $display("%0d ticks checked over %0d register settings", tracker.responses, settings_used);
      $display("%0d poll sequences finished, %0d acknowledges good",
               tracker.finished, tracker.good_acks);
      if (tracker.errors == 0 && tracker.expected_ticks.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
